@@ sv/brls_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap run-length scanner package
// Shared widths, codes, queue entry and result types, run-length helper.
// ----------------------------------------------------------------------------
package brls_pkg;

  localparam int unsigned PosW   = 40;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned OffW   = 3;
  localparam int unsigned CntW   = 4;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned InDataW  = 88;
  localparam int unsigned OutDataW = 128;
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = 1;
  localparam int unsigned QCntW  = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BIT_COUNT = 1'b0,
    CFG_ALL_RUNS  = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_CONT     = 2'd0,
    KIND_START    = 2'd1,
    KIND_PAST_END = 2'd2
  } kind_e;

  typedef struct packed {
    logic [ByteW-1:0] data;
    kind_e            kind;
    logic [PosW-1:0]  start;
    logic [PosW-1:0]  cap;
    logic             last;
  } item_t;

  typedef struct packed {
    logic            value;
    logic [PosW-1:0] length;
    logic [PosW-1:0] set_total;
    logic [PosW-1:0] unset_total;
    logic            final_run;
  } result_t;

  // Count of low bits that are zero, 8 when none is set.
  function automatic logic [CntW-1:0] run_len(input logic [ByteW-1:0] diff);
    logic [CntW-1:0] cnt;
    cnt = CntW'(ByteW);
    for (int i = ByteW - 1; i >= 0; i--) begin
      if (diff[i]) begin
        cnt = CntW'(i);
      end
    end
    return cnt;
  endfunction

endpackage

@@ sv/brls_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap run-length scanner front end
// Unpacks an input transfer and classifies it as scan start, start past the
// end of the bitmap, or continuation byte.
// ----------------------------------------------------------------------------
module brls_front import brls_pkg::*; (
  input  logic               in_valid_i,
  input  logic [InDataW-1:0] in_data_i,
  input  logic               in_first_i,
  input  logic               in_last_i,
  input  logic [PosW-1:0]    bit_count_i,
  output logic               push_o,
  output item_t              item_o
);

  logic [PosW-1:0] start;

  assign start = in_data_i[ByteW +: PosW];

  always_comb begin
    item_o.data  = in_data_i[ByteW-1:0];
    item_o.start = start;
    item_o.cap   = in_data_i[ByteW+PosW +: PosW];
    item_o.last  = in_last_i;
    if (!in_first_i) begin
      item_o.kind = KIND_CONT;
    end else if (start >= bit_count_i) begin
      item_o.kind = KIND_PAST_END;
    end else begin
      item_o.kind = KIND_START;
    end
  end

  assign push_o = in_valid_i;

endmodule

@@ sv/brls_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap run-length scanner item queue
// Two-entry queue between front end and run engine.
// ----------------------------------------------------------------------------
module brls_queue import brls_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  ready_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  item_t            mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, wr_d;
  logic [QPtrW-1:0] rd_q, rd_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign ready_o = (cnt_q != QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

@@ sv/brls_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap run-length scanner run engine
// Walks the queued byte one run segment per cycle while a stalled output does
// not hold it, keeps scan state and drives the result output register.
// ----------------------------------------------------------------------------
module brls_back import brls_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  item_t           head_i,
  output logic            pop_o,
  input  logic [PosW-1:0] bit_count_i,
  input  logic            all_runs_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output result_t         out_o
);

  logic            active_q, active_d;
  logic            mid_q, mid_d;
  logic [OffW-1:0] k_q, k_d;
  logic            val_q, val_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] len_q, len_d;
  logic [PosW-1:0] set_q, set_d;
  logic [PosW-1:0] unset_q, unset_d;
  logic [PosW-1:0] cap_q, cap_d;
  logic            capen_q, capen_d;
  logic            ov_q, ov_d;
  result_t         res_q, res_d;

  logic            start_now, active_e, capen_e, v_e;
  logic [OffW-1:0] k_e;
  logic [PosW-1:0] pos_e, len_e, set_e, unset_e, cap_e, need;
  logic [PosW-1:0] avail, cons_w, len_new;
  logic [CntW-1:0] room, nb, tz, r, cons;
  logic            past, over, avail_le, cap_hit, trans;
  logic [ByteW-1:0] shifted, diff;
  logic            need_emit, emit_final, fire, out_free, pop;
  logic            upd_state, end_scan, keep_mid, is_past;

  assign start_now = (head_i.kind == KIND_START) && !mid_q;
  assign pos_e     = start_now ? head_i.start : pos_q;
  assign len_e     = start_now ? '0 : len_q;
  assign set_e     = start_now ? '0 : set_q;
  assign unset_e   = start_now ? '0 : unset_q;
  assign cap_e     = start_now ? head_i.cap : cap_q;
  assign capen_e   = start_now ? (head_i.cap != '0) : capen_q;
  assign active_e  = start_now ? 1'b1 : active_q;
  assign k_e       = start_now ? head_i.start[OffW-1:0] : (mid_q ? k_q : '0);

  assign past     = (pos_e >= bit_count_i);
  assign avail    = bit_count_i - pos_e;
  assign room     = CntW'(ByteW) - {1'b0, k_e};
  assign avail_le = past ||
                    ((avail[PosW-1:CntW] == '0) && (avail[CntW-1:0] <= room));
  assign nb       = past ? '0 : (avail_le ? avail[CntW-1:0] : room);

  assign shifted = head_i.data >> k_e;
  assign v_e     = (len_e == '0) ? shifted[0] : val_q;
  assign diff    = v_e ? ~shifted : shifted;
  assign tz      = run_len(diff);
  assign r       = (tz < nb) ? tz : nb;

  assign need    = cap_e - len_e;
  assign over    = (len_e >= cap_e);
  assign cap_hit = !all_runs_i && capen_e && (r != '0) &&
                   (over || ((need[PosW-1:CntW] == '0) && (need[CntW-1:0] <= r)));
  assign trans   = (r < nb);

  always_comb begin
    need_emit  = 1'b0;
    emit_final = 1'b0;
    pop        = 1'b0;
    upd_state  = 1'b0;
    end_scan   = 1'b0;
    keep_mid   = 1'b0;
    is_past    = 1'b0;
    cons       = nb;
    case (head_i.kind)
      KIND_PAST_END: begin
        is_past    = 1'b1;
        need_emit  = 1'b1;
        emit_final = 1'b1;
        pop        = 1'b1;
      end
      KIND_START, KIND_CONT: begin
        if (!active_e) begin
          pop = 1'b1;
        end else if (cap_hit) begin
          upd_state  = 1'b1;
          cons       = over ? CntW'(1) : need[CntW-1:0];
          need_emit  = 1'b1;
          emit_final = 1'b1;
          end_scan   = 1'b1;
          pop        = 1'b1;
        end else if (trans) begin
          upd_state = 1'b1;
          cons      = r;
          need_emit = 1'b1;
          if (all_runs_i) begin
            keep_mid = 1'b1;
          end else begin
            emit_final = 1'b1;
            end_scan   = 1'b1;
            pop        = 1'b1;
          end
        end else begin
          upd_state = 1'b1;
          cons      = nb;
          pop       = 1'b1;
          if (avail_le || head_i.last) begin
            need_emit  = 1'b1;
            emit_final = 1'b1;
            end_scan   = 1'b1;
          end
        end
      end
      default: begin
        pop = 1'b1;
      end
    endcase
  end

  assign cons_w   = {{(PosW-CntW){1'b0}}, cons};
  assign len_new  = len_e + cons_w;
  assign out_free = !ov_q || out_ready_i;
  assign fire     = head_valid_i && (!need_emit || out_free);
  assign pop_o    = fire && pop;

  always_comb begin
    active_d = active_q;
    mid_d    = mid_q;
    k_d      = k_q;
    val_d    = val_q;
    pos_d    = pos_q;
    len_d    = len_q;
    set_d    = set_q;
    unset_d  = unset_q;
    cap_d    = cap_q;
    capen_d  = capen_q;
    if (fire && is_past) begin
      active_d = 1'b0;
      mid_d    = 1'b0;
    end else if (fire && upd_state) begin
      active_d = !end_scan;
      mid_d    = keep_mid;
      k_d      = k_e + r[OffW-1:0];
      val_d    = v_e;
      pos_d    = pos_e + cons_w;
      len_d    = keep_mid ? '0 : len_new;
      set_d    = v_e ? set_e + cons_w : set_e;
      unset_d  = v_e ? unset_e : unset_e + cons_w;
      cap_d    = cap_e;
      capen_d  = capen_e;
    end
  end

  always_comb begin
    ov_d  = ov_q && !out_ready_i;
    res_d = res_q;
    if (fire && need_emit) begin
      ov_d              = 1'b1;
      res_d.final_run   = emit_final;
      res_d.value       = is_past ? 1'b0 : v_e;
      res_d.length      = is_past ? '0 : len_new;
      res_d.set_total   = is_past ? '0 : (v_e ? set_e + cons_w : set_e);
      res_d.unset_total = is_past ? '0 : (v_e ? unset_e : unset_e + cons_w);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      mid_q    <= 1'b0;
      k_q      <= '0;
      val_q    <= 1'b0;
      pos_q    <= '0;
      len_q    <= '0;
      set_q    <= '0;
      unset_q  <= '0;
      cap_q    <= '0;
      capen_q  <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      active_q <= active_d;
      mid_q    <= mid_d;
      k_q      <= k_d;
      val_q    <= val_d;
      pos_q    <= pos_d;
      len_q    <= len_d;
      set_q    <= set_d;
      unset_q  <= unset_d;
      cap_q    <= cap_d;
      capen_q  <= capen_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = ov_q;
  assign out_o       = res_q;

endmodule

@@ sv/bitmap_run_length_scanner_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap run-length scanner
// Finds runs of equal bits in a byte-streamed allocation bitmap.
//
//   Channel   Direction  Handshake                  Payload
//   s_axis    in         s_axis_tvalid/tready       bitmap byte, start, cap
//   m_axis    out        m_axis_tvalid/tready       run value, length, totals
//   cfg       in         cfg_valid_i/cfg_ready_o    register index and value
//
// The run engine handles one segment of a byte per cycle unless a stalled
// output holds it. In all-runs mode each change of value in a byte's scanned
// bits, counting a change against the previous byte, ends a segment and the
// rest of the byte makes one more; in single mode every byte is one segment.
// A two-entry queue lets the front end take bytes while results drain.
// Reset clears all scan state; no scan runs after reset.
// Results wait in an output register; a stalled output holds the run engine
// whenever it has a run to emit.
// ----------------------------------------------------------------------------
module bitmap_run_length_scanner_top import brls_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // data_byte [7:0], start_bit [47:8], max_run [87:48]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // first [0]
  input  logic                s_axis_tuser,
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // run_value [0], run_length [40:1], set_total [80:41], unset_total [120:81]
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic                m_axis_tlast,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [PosW-1:0]     cfg_data_i
);

  logic [PosW-1:0] bit_count_q, bit_count_d;
  logic            all_runs_q, all_runs_d;
  logic            push, q_ready, head_valid, pop;
  item_t           push_item, head_item;
  result_t         res;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    bit_count_d = bit_count_q;
    all_runs_d  = all_runs_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_BIT_COUNT: bit_count_d = cfg_data_i;
        CFG_ALL_RUNS:  all_runs_d  = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_count_q <= '0;
      all_runs_q  <= 1'b0;
    end else begin
      bit_count_q <= bit_count_d;
      all_runs_q  <= all_runs_d;
    end
  end

  brls_front u_front (
    .in_valid_i  (s_axis_tvalid),
    .in_data_i   (s_axis_tdata),
    .in_first_i  (s_axis_tuser),
    .in_last_i   (s_axis_tlast),
    .bit_count_i (bit_count_q),
    .push_o      (push),
    .item_o      (push_item)
  );

  brls_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (head_valid),
    .item_o  (head_item)
  );

  brls_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_item),
    .pop_o        (pop),
    .bit_count_i  (bit_count_q),
    .all_runs_i   (all_runs_q),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_o        (res)
  );

  assign s_axis_tready = q_ready;
  assign m_axis_tlast  = res.final_run;
  assign m_axis_tdata  = {{(OutDataW-3*PosW-1){1'b0}},
                          res.unset_total, res.set_total, res.length, res.value};

endmodule

@@ tb/brls_run_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap run-length scanner checker
// Watches the configuration, bitmap and run channels of the scanner. Keeps its
// own copy of the registers and scan state, works out the runs each accepted
// bitmap byte must produce, and compares every run transfer field by field
// with the oldest outstanding run. Hands the mismatch count and the number of
// runs still outstanding to the testbench top.
// ----------------------------------------------------------------------------
module brls_run_checker import brls_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic                s_axis_tuser,
  input  logic                s_axis_tlast,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata,
  input  logic                m_axis_tlast,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [PosW-1:0]     cfg_data_i,
  output int unsigned         fail_count_o,
  output int unsigned         runs_pending_o
);

  logic [PosW-1:0] bit_count_q   = '0;
  logic            all_runs_q    = 1'b0;
  logic [PosW-1:0] position_q    = '0;
  logic            run_value_q   = 1'b0;
  logic [PosW-1:0] run_length_q  = '0;
  logic [PosW-1:0] set_bits_q    = '0;
  logic [PosW-1:0] clear_bits_q  = '0;
  logic            scanning_q    = 1'b0;
  logic [PosW-1:0] run_cap_q     = '0;
  result_t         expected_runs[$];

  task automatic report_mismatch(input string what, input logic [PosW-1:0] got,
                                 input logic [PosW-1:0] want);
    $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  task automatic push_run(input logic value, input logic [PosW-1:0] length,
                          input logic final_run);
    result_t r;
    r.value       = value;
    r.length      = length;
    r.set_total   = set_bits_q;
    r.unset_total = clear_bits_q;
    r.final_run   = final_run;
    expected_runs.push_back(r);
  endtask

  task automatic scan_byte(input logic [ByteW-1:0] data, input logic first,
                           input logic [PosW-1:0] start, input logic [PosW-1:0] cap,
                           input logic last);
    int   k;
    logic b;
    logic done;
    k    = 0;
    done = 1'b0;
    if (first) begin
      set_bits_q   = '0;
      clear_bits_q = '0;
      run_length_q = '0;
      run_value_q  = 1'b0;
      run_cap_q    = cap;
      position_q   = start;
      if (start >= bit_count_q) begin
        scanning_q = 1'b0;
        push_run(1'b0, '0, 1'b1);
        done = 1'b1;
      end else begin
        scanning_q = 1'b1;
        k = int'(start[OffW-1:0]);
      end
    end
    if (!done && scanning_q) begin
      while (!done && k < ByteW && position_q < bit_count_q) begin
        b = data[k];
        if (run_length_q == '0) begin
          run_value_q = b;
        end else if (b != run_value_q) begin
          if (!all_runs_q) begin
            scanning_q = 1'b0;
            push_run(run_value_q, run_length_q, 1'b1);
            done = 1'b1;
          end else begin
            push_run(run_value_q, run_length_q, 1'b0);
            run_value_q  = b;
            run_length_q = '0;
          end
        end
        if (!done) begin
          run_length_q = run_length_q + 1'b1;
          if (b) begin
            set_bits_q = set_bits_q + 1'b1;
          end else begin
            clear_bits_q = clear_bits_q + 1'b1;
          end
          position_q = position_q + 1'b1;
          if (!all_runs_q && run_cap_q != '0 && run_length_q >= run_cap_q) begin
            scanning_q = 1'b0;
            push_run(run_value_q, run_length_q, 1'b1);
            done = 1'b1;
          end
        end
        k++;
      end
      if (!done && (position_q >= bit_count_q || last)) begin
        scanning_q = 1'b0;
        push_run(run_value_q, run_length_q, 1'b1);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      bit_count_q  = '0;
      all_runs_q   = 1'b0;
      position_q   = '0;
      run_value_q  = 1'b0;
      run_length_q = '0;
      set_bits_q   = '0;
      clear_bits_q = '0;
      scanning_q   = 1'b0;
      run_cap_q    = '0;
      expected_runs.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_BIT_COUNT: bit_count_q = cfg_data_i;
          CFG_ALL_RUNS:  all_runs_q  = cfg_data_i[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        scan_byte(s_axis_tdata[ByteW-1:0], s_axis_tuser,
                  s_axis_tdata[ByteW+PosW-1:ByteW],
                  s_axis_tdata[ByteW+2*PosW-1:ByteW+PosW], s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.value       = m_axis_tdata[0];
        got.length      = m_axis_tdata[PosW:1];
        got.set_total   = m_axis_tdata[2*PosW:PosW+1];
        got.unset_total = m_axis_tdata[3*PosW:2*PosW+1];
        got.final_run   = m_axis_tlast;
        if (expected_runs.size() == 0) begin
          report_mismatch("run with none outstanding, length", got.length, '0);
        end else begin
          want = expected_runs.pop_front();
          if (got.value !== want.value) begin
            report_mismatch("run_value", PosW'(got.value), PosW'(want.value));
          end
          if (got.length !== want.length) begin
            report_mismatch("run_length", got.length, want.length);
          end
          if (got.set_total !== want.set_total) begin
            report_mismatch("set_total", got.set_total, want.set_total);
          end
          if (got.unset_total !== want.unset_total) begin
            report_mismatch("unset_total", got.unset_total, want.unset_total);
          end
          if (got.final_run !== want.final_run) begin
            report_mismatch("final_run", PosW'(got.final_run), PosW'(want.final_run));
          end
        end
      end
    end
    runs_pending_o = $unsigned(expected_runs.size());
  end

endmodule

@@ tb/tb_bitmap_run_length_scanner_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap run-length scanner testbench
// Drives bitmap bytes and register writes into the scanner with random gaps
// and output stalls. A directed part covers partial first bytes, starts past
// the end, run caps, ignored bytes, abandoned scans, dense transitions and
// the widest positions; random scans then run under several register
// settings. The run checker beside the scanner predicts and compares.
// ----------------------------------------------------------------------------
module tb_bitmap_run_length_scanner_top;
  import brls_pkg::*;

  localparam logic [PosW-1:0] MaxPos      = '1;
  localparam int unsigned     DrainCycles = 16;
  localparam int unsigned     CycleLimit  = 400000;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                s_axis_tlast  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [PosW-1:0]     cfg_data_i    = '0;

  int unsigned         fail_count;
  int unsigned         runs_pending;
  int unsigned         cycle_count   = 0;
  int unsigned         stall_left    = 0;
  bit                  calm_send     = 1'b0;
  bit                  calm_recv     = 1'b0;
  logic [PosW-1:0]     bit_count_set = '0;

  bitmap_run_length_scanner_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  brls_run_checker i_run_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .s_axis_tlast   (s_axis_tlast),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tlast   (m_axis_tlast),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .fail_count_o   (fail_count),
    .runs_pending_o (runs_pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL bitmap_run_length_scanner_top");
      $finish;
    end
  end

  // Stall the run channel: mostly short holds, a few long ones.
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (!calm_recv && $urandom_range(0, 99) < 25) begin
      m_axis_tready <= 1'b0;
      stall_left    <= ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2)
                                                    : $urandom_range(5, 40);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic logic [PosW-1:0] rand_pos();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[PosW-1:0];
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm_send || r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [ByteW-1:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      return 8'h00;
    end
    if (r < 30) begin
      return 8'hFF;
    end
    if (r < 45) begin
      return ($urandom_range(0, 1) != 0) ? (8'hFF << $urandom_range(0, 7))
                                         : ~(8'hFF << $urandom_range(0, 7));
    end
    if (r < 55) begin
      return ($urandom_range(0, 1) != 0) ? 8'h55 : 8'hAA;
    end
    return 8'($urandom);
  endfunction

  task automatic send_byte(input logic [ByteW-1:0] data, input logic first,
                           input logic [PosW-1:0] start, input logic [PosW-1:0] cap,
                           input logic last);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  = {cap, start, data};
    s_axis_tuser  = first;
    s_axis_tlast  = last;
    s_axis_tvalid = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [PosW-1:0] value);
    cfg_index_i = idx;
    cfg_data_i  = value;
    cfg_valid_i = 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (runs_pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic set_config(input logic [PosW-1:0] bit_count, input logic all_runs);
    wait_drained();
    write_reg(CFG_BIT_COUNT, bit_count);
    write_reg(CFG_ALL_RUNS, {{(PosW-1){1'b0}}, all_runs});
    bit_count_set = bit_count;
  endtask

  task automatic random_scan();
    logic [PosW-1:0] start;
    logic [PosW-1:0] cap;
    int unsigned     nbytes;
    int unsigned     r;
    r = $urandom_range(0, 99);
    if (bit_count_set <= 64) begin
      start = PosW'($urandom_range(0, int'(bit_count_set) + 9));
    end else if (r < 8) begin
      start = bit_count_set + PosW'($urandom_range(0, 3));
    end else if (r < 30) begin
      start = bit_count_set - PosW'($urandom_range(1, 40));
    end else begin
      start = rand_pos() % bit_count_set;
    end
    r = $urandom_range(0, 99);
    cap = (r < 45) ? '0 : (r < 80) ? PosW'($urandom_range(1, 24)) : rand_pos();
    nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
    for (int i = 0; i < nbytes; i++) begin
      send_byte(pick_byte(), i == 0, (i == 0) ? start : rand_pos(),
                (i == 0) ? cap : rand_pos(),
                (i == nbytes - 1) && ($urandom_range(0, 3) != 0));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    set_config(40'd64, 1'b0);
    send_byte(8'h00, 1'b1, 40'd0, 40'd0, 1'b0);
    send_byte(8'h0F, 1'b0, 40'd0, 40'd0, 1'b0);
    send_byte(8'hF8, 1'b1, 40'd3, 40'd0, 1'b1);
    send_byte(8'h00, 1'b1, 40'd64, 40'd0, 1'b0);
    send_byte(8'h00, 1'b1, 40'd0, 40'd3, 1'b0);
    send_byte(8'hFF, 1'b0, 40'd0, 40'd0, 1'b0);
    send_byte(8'hFF, 1'b1, 40'd60, 40'd0, 1'b0);
    send_byte(8'h00, 1'b1, 40'd8, 40'd0, 1'b0);
    send_byte(8'hAA, 1'b1, 40'd17, 40'd0, 1'b1);
    set_config(40'd64, 1'b1);
    send_byte(8'h55, 1'b1, 40'd0, 40'd0, 1'b0);
    send_byte(8'hAA, 1'b0, 40'd0, 40'd0, 1'b1);
    send_byte(8'hFF, 1'b1, 40'd5, 40'd7, 1'b0);
    send_byte(8'hFF, 1'b0, 40'd0, 40'd0, 1'b0);
    send_byte(8'h01, 1'b0, 40'd0, 40'd0, 1'b1);
    set_config(MaxPos, 1'b1);
    send_byte(8'h0F, 1'b1, MaxPos - 40'd7, MaxPos, 1'b0);
    set_config(MaxPos, 1'b0);
    send_byte(8'hFF, 1'b1, 40'd0, MaxPos, 1'b0);
    send_byte(8'hFF, 1'b0, MaxPos, MaxPos, 1'b0);
    send_byte(8'h7F, 1'b0, MaxPos, MaxPos, 1'b1);
    set_config(40'd0, 1'b0);
    send_byte(8'h01, 1'b1, 40'd0, 40'd0, 1'b1);
    set_config(40'd1, 1'b1);
    send_byte(8'h01, 1'b1, 40'd0, 40'd0, 1'b0);

    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: set_config(40'd16, 1'b0);
        1: set_config(40'd40, 1'b1);
        2: set_config(rand_pos(), 1'b1);
        3: set_config(MaxPos, 1'b0);
        4: set_config(MaxPos, 1'b1);
        5: set_config(40'd0, 1'b1);
        6: set_config(PosW'($urandom_range(1, 100)), 1'($urandom_range(0, 1)));
        7: set_config(rand_pos(), 1'b0);
        default: set_config(40'd8, 1'b1);
      endcase
      calm_send = (ph == 2 || ph == 6);
      calm_recv = (ph == 3 || ph == 6);
      for (int s = 0; s < ((ph == 5) ? 3 : 6); s++) begin
        if ($urandom_range(0, 99) < 8) begin
          send_byte(pick_byte(), 1'b0, rand_pos(), rand_pos(), 1'($urandom_range(0, 1)));
        end
        random_scan();
      end
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("PASS bitmap_run_length_scanner_top");
    end else begin
      $display("FAIL bitmap_run_length_scanner_top");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/brls_pkg.sv
sv/brls_front.sv
sv/brls_queue.sv
sv/brls_back.sv
sv/bitmap_run_length_scanner_top.sv
tb/brls_run_checker.sv
tb/tb_bitmap_run_length_scanner_top.sv
